// ----- hw/rtl/wioe_pkg.sv -----
// ----------------------------------------------------------------------------
// wioe_pkg
// Shared widths, codes and controller/datapath interface types for the
// window interval overlap extremes unit.
// ----------------------------------------------------------------------------
package wioe_pkg;

  // field and store geometry
  localparam int DAY_BITS       = 11;
  localparam int MAX_DAYS       = 1024;
  localparam int ADDR_BITS      = $clog2(MAX_DAYS + 1);
  localparam int COUNT_BITS     = 16;
  localparam int SUM_BITS       = COUNT_BITS + ADDR_BITS;
  localparam int OV_BITS        = SUM_BITS + 1;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = DAY_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [ADDR_BITS-1:0]  LAST_ADDR = ADDR_BITS'(MAX_DAYS);

  // register reset values
  localparam logic [DAY_BITS-1:0] DAY_COUNT_RESET  = DAY_BITS'(1024);
  localparam logic [DAY_BITS-1:0] WINDOW_LEN_RESET = DAY_BITS'(1);

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DAY_COUNT  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LEN = 1'b1;

  // request opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_capture;
    logic load_write;
    logic scan_init;
    logic scan_issue;
    logic res_load;
    logic clr_init;
    logic clr_write;
  } wioe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic pipe_busy;
    logic clr_last;
    logic out_free;
  } wioe_status_t;

endpackage

// ----- hw/rtl/window_interval_overlap_extremes_unit.sv -----
// ----------------------------------------------------------------------------
// window_interval_overlap_extremes_unit
// Interval histogram loader with a sliding-window overlap scan that reports
// the earliest window starts with the most and the fewest overlaps.
// ----------------------------------------------------------------------------
// load request: store read, then saturating write back, one at a time
// finish request: a scan of every day up to min(day_count,1024), a pipeline drain
//   and a result register load once the output is free; then a clear of the
//   whole store runs before the next request is taken
// reset: a clear of both stores runs before the first request;
//   configuration writes are taken throughout
module window_interval_overlap_extremes_unit import wioe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      op,
  input  logic [DAY_BITS-1:0]       left_day,
  input  logic [DAY_BITS-1:0]       right_day,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [DAY_BITS-1:0]       max_start,
  output logic [DAY_BITS-1:0]       min_start
);

  // command and status between sequencer and datapath
  wioe_cmd_t    cmd;
  wioe_status_t status;

  // sequencer: owns the request handshake and the phase order
  wioe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: stores, scan pipeline, result register
  wioe_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .left_day   (left_day),
    .right_day  (right_day),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .max_start  (max_start),
    .min_start  (min_start),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

// ----- hw/rtl/wioe_ctrl.sv -----
// ----------------------------------------------------------------------------
// wioe_ctrl
// Sequencer: store clearing, interval loads, finish scan and result handoff.
// ----------------------------------------------------------------------------
module wioe_ctrl import wioe_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         op,
  output logic         in_stall,
  input  wioe_status_t status,
  output wioe_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_LOAD   = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (op == OP_LOAD) begin
            cmd.load_capture = 1'b1;
            state_next       = ST_LOAD;
          end else begin
            cmd.scan_init = 1'b1;
            state_next    = ST_SCAN;
          end
        end
      end
      ST_LOAD: begin
        cmd.load_write = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.res_load = 1'b1;
          cmd.clr_init = 1'b1;
          state_next   = ST_CLEAR;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- hw/rtl/wioe_datapath.sv -----
// ----------------------------------------------------------------------------
// wioe_datapath
// Histogram stores, prefix-sum scan pipeline, extreme tracking and result
// register.
// ----------------------------------------------------------------------------
module wioe_datapath import wioe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [DAY_BITS-1:0]       left_day,
  input  logic [DAY_BITS-1:0]       right_day,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic [DAY_BITS-1:0]       max_start,
  output logic [DAY_BITS-1:0]       min_start,
  input  wioe_cmd_t                 cmd,
  output wioe_status_t              status
);

  logic [COUNT_BITS-1:0] start_mem [0:MAX_DAYS];
  logic [COUNT_BITS-1:0] end_mem   [0:MAX_DAYS];

  logic [DAY_BITS-1:0]   day_count, window_len;
  logic [ADDR_BITS-1:0]  start_raddr, end_raddr, start_waddr, end_waddr;
  logic [COUNT_BITS-1:0] start_rdata, end_rdata, start_wdata, end_wdata;
  logic                  start_we, end_we;

  logic [ADDR_BITS-1:0]  left_addr, right_addr;
  logic                  left_ok, right_ok;

  logic [ADDR_BITS-1:0]  clr_ptr;
  logic [ADDR_BITS-1:0]  ptr;
  logic [ADDR_BITS-1:0]  days_lim;
  logic                  fits;
  logic                  ptr_past_w;

  logic                  a_valid, a_eval, a_end;
  logic [DAY_BITS-1:0]   a_start;
  logic                  b_valid, b_eval;
  logic [DAY_BITS-1:0]   b_start;
  logic [SUM_BITS-1:0]   start_sum, end_sum;
  logic                  c_valid, c_eval;
  logic [DAY_BITS-1:0]   c_start;
  logic signed [OV_BITS-1:0] overlap;

  logic                  first;
  logic signed [OV_BITS-1:0] best_hi, best_lo;
  logic [DAY_BITS-1:0]   hi_start, lo_start;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      day_count  <= DAY_COUNT_RESET;
      window_len <= WINDOW_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DAY_COUNT:  day_count  <= cfg_data;
        CFG_WINDOW_LEN: window_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // scan pointer compare against window length
  assign ptr_past_w = ({{DAY_BITS{1'b0}}, ptr} >= {{ADDR_BITS{1'b0}}, window_len});

  // read addresses: scan pointers while scanning, request days otherwise
  always_comb begin
    if (cmd.scan_issue) begin
      start_raddr = ptr;
      end_raddr   = ADDR_BITS'(ptr - ADDR_BITS'(window_len));
    end else begin
      start_raddr = ADDR_BITS'(left_day);
      end_raddr   = ADDR_BITS'(right_day);
    end
  end

  // write side: saturating increment on load, zero on clear
  always_comb begin
    if (cmd.clr_write) begin
      start_we    = 1'b1;
      end_we      = 1'b1;
      start_waddr = clr_ptr;
      end_waddr   = clr_ptr;
      start_wdata = '0;
      end_wdata   = '0;
    end else begin
      start_we    = cmd.load_write && left_ok;
      end_we      = cmd.load_write && right_ok;
      start_waddr = left_addr;
      end_waddr   = right_addr;
      start_wdata = (start_rdata < COUNT_MAX) ? start_rdata + 1'b1 : start_rdata;
      end_wdata   = (end_rdata < COUNT_MAX) ? end_rdata + 1'b1 : end_rdata;
    end
  end

  always_ff @(posedge clk) begin
    start_rdata <= start_mem[start_raddr];
    end_rdata   <= end_mem[end_raddr];
    if (start_we) begin
      start_mem[start_waddr] <= start_wdata;
    end
    if (end_we) begin
      end_mem[end_waddr] <= end_wdata;
    end
  end

  // load address capture
  always_ff @(posedge clk) begin
    if (cmd.load_capture) begin
      left_addr  <= ADDR_BITS'(left_day);
      right_addr <= ADDR_BITS'(right_day);
      left_ok    <= (32'(left_day) <= MAX_DAYS);
      right_ok   <= (32'(right_day) <= MAX_DAYS);
    end
  end

  // clear sweep pointer
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_init) begin
      clr_ptr <= '0;
    end else if (cmd.clr_write && clr_ptr != LAST_ADDR) begin
      clr_ptr <= clr_ptr + 1'b1;
    end
  end

  // scan pointer and case limits
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      ptr      <= '0;
      days_lim <= (32'(day_count) > MAX_DAYS) ? LAST_ADDR : ADDR_BITS'(day_count);
      fits     <= (32'(window_len) <= MAX_DAYS) &&
                  (window_len <= day_count);
    end else if (cmd.scan_issue) begin
      ptr <= ptr + 1'b1;
    end
  end

  // stage a: memory data returning
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_init) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= cmd.scan_issue;
    end
    a_end   <= ptr_past_w;
    a_eval  <= ptr_past_w && fits;
    a_start <= DAY_BITS'(ptr - ADDR_BITS'(window_len) + 1'b1);
  end

  // stage b: running prefix sums
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_init) begin
      b_valid   <= 1'b0;
      start_sum <= '0;
      end_sum   <= '0;
    end else begin
      b_valid <= a_valid;
      if (a_valid) begin
        start_sum <= start_sum + SUM_BITS'(start_rdata);
        if (a_end) begin
          end_sum <= end_sum + SUM_BITS'(end_rdata);
        end
      end
    end
    b_eval  <= a_valid && a_eval;
    b_start <= a_start;
  end

  // stage c: window overlap
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_init) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
    c_eval  <= b_valid && b_eval;
    c_start <= b_start;
    overlap <= $signed({1'b0, start_sum}) - $signed({1'b0, end_sum});
  end

  // stage d: earliest max and min
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_init) begin
      first    <= 1'b1;
      hi_start <= '0;
      lo_start <= '0;
    end else if (c_valid && c_eval) begin
      first <= 1'b0;
      if (first || overlap > best_hi) begin
        best_hi  <= overlap;
        hi_start <= c_start;
      end
      if (first || overlap < best_lo) begin
        best_lo  <= overlap;
        lo_start <= c_start;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      max_start <= hi_start;
      min_start <= lo_start;
    end
  end

  assign status.scan_last = (ptr == days_lim);
  assign status.pipe_busy = a_valid || b_valid || c_valid;
  assign status.clr_last  = (clr_ptr == LAST_ADDR);
  assign status.out_free  = !out_valid || !out_stall;

endmodule

// ----- tb/window_interval_overlap_extremes_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_interval_overlap_extremes_unit_tb
// Self-checking bench for the interval overlap extremes unit. A directed table
// hits the corner shapes (empty case, no window fits, zero window, oversized
// day count, day zero, out-of-store days, reversed intervals), then random
// cases of interval loads closed by a finish.
// Every accepted request updates a local histogram model; every finish
// queues the predicted pair of window starts, matched in order on the output.
// ----------------------------------------------------------------------------
module window_interval_overlap_extremes_unit_tb import wioe_pkg::*; ();

  // block latency after the last result: the store clear plus some margin
  localparam int SETTLE_CYCLES    = 1100;
  localparam int HOLD_OFF_CYCLES  = 6000;
  localparam int RANDOM_REQS      = 1600;
  localparam int RANDOM_FINISHES  = 48;
  localparam int MAX_PRINTED      = 40;
  localparam longint TIMEOUT_NS   = 40_000_000;

  typedef struct packed {
    logic [DAY_BITS-1:0] max_start;
    logic [DAY_BITS-1:0] min_start;
  } window_pick_t;

  // directed rows: program a shape, send a request, or send a request whose
  // result is typed in by hand
  typedef enum logic [1:0] {ROW_SHAPE, ROW_REQ, ROW_PINNED} stim_kind_t;

  typedef struct packed {
    stim_kind_t          kind;
    logic                op;
    logic [DAY_BITS-1:0] a;     // left day, or day_count for a shape row
    logic [DAY_BITS-1:0] b;     // right day, or window_len for a shape row
    window_pick_t        want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 33;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic                      op;
  logic [DAY_BITS-1:0]       left_day;
  logic [DAY_BITS-1:0]       right_day;
  logic                      out_valid;
  logic                      out_stall;
  logic [DAY_BITS-1:0]       max_start;
  logic [DAY_BITS-1:0]       min_start;

  // local copy of the block's histograms and registers
  logic [COUNT_BITS-1:0] start_cnt [0:MAX_DAYS];
  logic [COUNT_BITS-1:0] end_cnt   [0:MAX_DAYS];
  longint                start_pre [0:MAX_DAYS];
  longint                end_pre   [0:MAX_DAYS];
  logic [DAY_BITS-1:0]   day_count_m;
  logic [DAY_BITS-1:0]   window_len_m;

  window_pick_t pick_q [$];   // window starts still owed by the block
  window_pick_t want_pick;

  int  mismatches      = 0;
  int  results_checked = 0;
  int  reqs_sent       = 0;
  int  finishes_sent   = 0;
  int  shapes_set      = 0;
  int  burst_left      = 0;
  bit  hold_off_req    = 1'b0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // empty case under reset shape: every window overlaps nothing
    '{ROW_PINNED, OP_FINISH, 11'd0,    11'd0,    '{11'd1, 11'd1}},
    '{ROW_REQ,    OP_LOAD,   11'd1,    11'd1024, '0},
    '{ROW_REQ,    OP_LOAD,   11'd1024, 11'd1024, '0},
    '{ROW_REQ,    OP_LOAD,   11'd0,    11'd0,    '0},   // day zero is counted
    '{ROW_REQ,    OP_LOAD,   11'd700,  11'd300,  '0},   // reversed interval
    '{ROW_REQ,    OP_LOAD,   11'd2047, 11'd2047, '0},   // both days off the store
    '{ROW_REQ,    OP_LOAD,   11'd5,    11'd1025, '0},
    '{ROW_REQ,    OP_LOAD,   11'd1025, 11'd9,    '0},
    '{ROW_REQ,    OP_FINISH, 11'd2047, 11'd2047, '0},
    // day count above the store depth is cut to the store
    '{ROW_SHAPE,  OP_LOAD,   11'd2047, 11'd1,    '0},
    '{ROW_REQ,    OP_LOAD,   11'd3,    11'd8,    '0},
    '{ROW_REQ,    OP_LOAD,   11'd10,   11'd12,   '0},
    '{ROW_REQ,    OP_FINISH, 11'd0,    11'd0,    '0},
    // no window fits
    '{ROW_SHAPE,  OP_LOAD,   11'd16,   11'd17,   '0},
    '{ROW_REQ,    OP_LOAD,   11'd2,    11'd4,    '0},
    '{ROW_PINNED, OP_FINISH, 11'd0,    11'd0,    '{11'd0, 11'd0}},
    '{ROW_SHAPE,  OP_LOAD,   11'd16,   11'd2047, '0},
    '{ROW_PINNED, OP_FINISH, 11'd1365, 11'd682,  '{11'd0, 11'd0}},
    // zero-length window
    '{ROW_SHAPE,  OP_LOAD,   11'd1024, 11'd0,    '0},
    '{ROW_REQ,    OP_LOAD,   11'd1,    11'd1,    '0},
    '{ROW_REQ,    OP_LOAD,   11'd1024, 11'd1024, '0},
    '{ROW_REQ,    OP_FINISH, 11'd0,    11'd0,    '0},
    '{ROW_SHAPE,  OP_LOAD,   11'd0,    11'd0,    '0},
    '{ROW_REQ,    OP_LOAD,   11'd0,    11'd0,    '0},
    '{ROW_REQ,    OP_FINISH, 11'd0,    11'd0,    '0},
    // smallest shape
    '{ROW_SHAPE,  OP_LOAD,   11'd1,    11'd1,    '0},
    '{ROW_REQ,    OP_LOAD,   11'd1,    11'd1,    '0},
    '{ROW_REQ,    OP_FINISH, 11'd0,    11'd0,    '0},
    // one window spanning the whole store
    '{ROW_SHAPE,  OP_LOAD,   11'd1024, 11'd1024, '0},
    '{ROW_REQ,    OP_LOAD,   11'd500,  11'd600,  '0},
    '{ROW_PINNED, OP_FINISH, 11'd0,    11'd0,    '{11'd1, 11'd1}},
    // no days at all
    '{ROW_SHAPE,  OP_LOAD,   11'd0,    11'd1,    '0},
    '{ROW_PINNED, OP_FINISH, 11'd0,    11'd0,    '{11'd0, 11'd0}}
  };

  window_interval_overlap_extremes_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .left_day  (left_day),
    .right_day (right_day),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .max_start (max_start),
    .min_start (min_start)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // one line per mismatch, quiet after the first few dozen
  task automatic report_mismatch(input string what, input logic [DAY_BITS-1:0] got,
                                 input logic [DAY_BITS-1:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("%0t ns mismatch on %s: got %0d, want %0d", $time, what, got, want);
    end
  endtask

  // histogram model: loads bump the per-day counters, a finish scans every
  // window and returns the earliest starts with the most and fewest overlaps
  function automatic bit model_request(input logic op_v, input logic [DAY_BITS-1:0] l,
                                       input logic [DAY_BITS-1:0] r,
                                       output window_pick_t pick);
    int     days;
    int     wl;
    longint ov;
    longint best_hi;
    longint best_lo;
    bit     seen;
    pick = '0;
    if (op_v == OP_LOAD) begin
      // days past the store are dropped, counters stick at all ones
      if (l <= MAX_DAYS && start_cnt[l] != COUNT_MAX) start_cnt[l]++;
      if (r <= MAX_DAYS && end_cnt[r] != COUNT_MAX) end_cnt[r]++;
      return 1'b0;
    end
    days = (day_count_m > MAX_DAYS) ? MAX_DAYS : int'(day_count_m);
    wl   = int'(window_len_m);
    start_pre[0] = longint'(start_cnt[0]);
    end_pre[0]   = longint'(end_cnt[0]);
    for (int e = 1; e <= days; e++) begin
      start_pre[e] = start_pre[e-1] + longint'(start_cnt[e]);
      end_pre[e]   = end_pre[e-1] + longint'(end_cnt[e]);
    end
    seen    = 1'b0;
    best_hi = 0;
    best_lo = 0;
    if (wl <= days) begin
      // signed compare: reversed intervals can push an overlap below zero
      for (int e = wl; e <= days; e++) begin
        ov = start_pre[e] - end_pre[e-wl];
        if (!seen || ov > best_hi) begin
          best_hi = ov;
          pick.max_start = DAY_BITS'(e - wl + 1);
        end
        if (!seen || ov < best_lo) begin
          best_lo = ov;
          pick.min_start = DAY_BITS'(e - wl + 1);
        end
        seen = 1'b1;
      end
    end
    foreach (start_cnt[d]) begin
      start_cnt[d] = '0;
      end_cnt[d]   = '0;
    end
    return 1'b1;
  endfunction

  // offer one request in the current burst, opening a new burst after a
  // random gap when the old one is used up
  task automatic send_req(input logic op_v, input logic [DAY_BITS-1:0] l,
                          input logic [DAY_BITS-1:0] r, input bit pinned,
                          input window_pick_t pinned_pick);
    window_pick_t pick;
    int unsigned  gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid  <= 1'b1;
    op        <= op_v;
    left_day  <= l;
    right_day <= r;
    do @(posedge clk); while (in_stall);
    reqs_sent++;
    if (model_request(op_v, l, r, pick)) begin
      pick_q.push_back(pinned ? pinned_pick : pick);
      finishes_sent++;
    end
  endtask

  // stop offering, let every owed result come out, then let the store clear
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pick_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers on back-to-back cycles so the write enable stays high
  task automatic program_shape(input logic [DAY_BITS-1:0] dc,
                               input logic [DAY_BITS-1:0] wl);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DAY_COUNT;
    cfg_data  <= dc;
    @(posedge clk);
    cfg_index <= CFG_WINDOW_LEN;
    cfg_data  <= wl;
    @(posedge clk);
    cfg_we       <= 1'b0;
    day_count_m  = dc;
    window_len_m = wl;
    shapes_set++;
  endtask

  // receiver: stall pattern changes after a random span, with one long
  // hold-off on request so the block backs up into its input
  initial begin
    int unsigned stall_mode;
    int unsigned span;
    bit          hold_off_done;
    hold_off_done = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      stall_mode = $urandom_range(0, 2);
      span       = $urandom_range(16, 400);
      repeat (span) begin
        if (hold_off_req && !hold_off_done) begin
          out_stall <= 1'b1;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
          hold_off_done = 1'b1;
        end
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // result checker: compare against the oldest owed pair
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pick_q.size() == 0) begin
        report_mismatch("unexpected result max_start", max_start, '0);
      end else begin
        want_pick = pick_q.pop_front();
        if (max_start !== want_pick.max_start) begin
          report_mismatch("max_start", max_start, want_pick.max_start);
        end
        if (min_start !== want_pick.min_start) begin
          report_mismatch("min_start", min_start, want_pick.min_start);
        end
        results_checked++;
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t           row;
    int                  dc;
    int                  wl;
    int                  eff;
    int                  span;
    int                  n_cases;
    int                  n_loads;
    int                  phase;
    int                  reqs_base;
    int                  finishes_base;
    logic [DAY_BITS-1:0] l;
    logic [DAY_BITS-1:0] r;

    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_DAY_COUNT;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    op        <= OP_LOAD;
    left_day  <= '0;
    right_day <= '0;
    foreach (start_cnt[d]) begin
      start_cnt[d] = '0;
      end_cnt[d]   = '0;
    end
    day_count_m  = DAY_COUNT_RESET;
    window_len_m = WINDOW_LEN_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_SHAPE) begin
        settle_block();
        program_shape(row.a, row.b);
      end else begin
        send_req(row.op, row.a, row.b, row.kind == ROW_PINNED, row.want);
      end
    end

    // random cases: one shape per phase, a few cases of loads closed by a finish
    reqs_base     = reqs_sent;
    finishes_base = finishes_sent;
    phase         = 0;
    while (reqs_sent - reqs_base < RANDOM_REQS ||
           finishes_sent - finishes_base < RANDOM_FINISHES) begin
      case ($urandom_range(0, 9))
        0:       dc = MAX_DAYS;
        1:       dc = $urandom_range(MAX_DAYS + 1, 2047);
        2:       dc = $urandom_range(0, 3);
        default: dc = $urandom_range(4, 96);
      endcase
      eff  = (dc > MAX_DAYS) ? MAX_DAYS : dc;
      span = (eff < 1) ? 1 : eff;
      case ($urandom_range(0, 9))
        0:       wl = 0;
        1:       wl = eff + $urandom_range(1, 3);
        2:       wl = $urandom_range(MAX_DAYS + 1, 2047);
        3:       wl = eff;
        default: wl = $urandom_range(1, (span > 4) ? span / 2 : 1);
      endcase
      settle_block();
      program_shape(DAY_BITS'(dc), DAY_BITS'(wl));

      n_cases = $urandom_range(1, 3);
      // once: receiver holds off while several cases keep coming
      if (phase == 3) begin
        hold_off_req = 1'b1;
        n_cases      = 4;
      end
      for (int c = 0; c < n_cases; c++) begin
        n_loads = $urandom_range(0, 40);
        for (int k = 0; k < n_loads; k++) begin
          case ($urandom_range(0, 9))
            0: begin   // anything the fields allow
              l = DAY_BITS'($urandom_range(0, 2047));
              r = DAY_BITS'($urandom_range(0, 2047));
            end
            1: begin   // reversed interval
              r = DAY_BITS'($urandom_range(1, span));
              l = DAY_BITS'($urandom_range(32'(r), span));
            end
            2: begin   // starts on day zero
              l = '0;
              r = DAY_BITS'($urandom_range(0, span));
            end
            default: begin
              l = DAY_BITS'($urandom_range(1, span));
              r = DAY_BITS'($urandom_range(32'(l), span));
            end
          endcase
          send_req(OP_LOAD, l, r, 1'b0, '0);
        end
        send_req(OP_FINISH, DAY_BITS'($urandom_range(0, 2047)),
                 DAY_BITS'($urandom_range(0, 2047)), 1'b0, '0);
      end
      phase++;
    end

    // drain and watch for stray results
    settle_block();

    $display("run covered %0d requests with %0d finishes over %0d window shapes",
             reqs_sent, finishes_sent, shapes_set);
    $display("checked %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && pick_q.size() == 0) begin
      $display("PASS window_interval_overlap_extremes_unit");
    end else begin
      $display("FAIL window_interval_overlap_extremes_unit");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL window_interval_overlap_extremes_unit");
    $finish;
  end

endmodule
